[sv/pgnh_pkg.sv]
`default_nettype none

package pgnh_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // Neighbor node types
   typedef enum logic [1:0] {
      NT_UAN  = 2'd0,
      NT_BUOY = 2'd1,
      NT_SAT  = 2'd2
   } node_kind_type;

   // Response status codes
   typedef enum logic [2:0] {
      STAT_LOADED  = 3'd0,
      STAT_DUP     = 3'd1,
      STAT_FULL    = 3'd2,
      STAT_CLEARED = 3'd3,
      STAT_FOUND   = 3'd4,
      STAT_NOROUTE = 3'd5
   } status_type;

   // CSR register indexes
   typedef enum logic [1:0] {
      CSR_IS_SAT = 2'd0,
      CSR_SELF_X = 2'd1,
      CSR_SELF_Y = 2'd2,
      CSR_SELF_Z = 2'd3
   } csr_index_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_DRAIN  = 2'd2,
      ST_FINISH = 2'd3
   } state_type;

   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned DIFF_W = 33;
   localparam int unsigned SQ_W = 66;
   localparam int unsigned DIST_W = 68;

   typedef struct packed {
      logic [1:0]         kind;
      logic [31:0]        addr;
      logic [1:0]         node_type;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        prev_hop_addr;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] next_hop_addr;
   } rsp_payload_type;

   // One neighbor table row
   typedef struct packed {
      logic [31:0]        addr;
      logic [1:0]         node_type;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } entry_type;

   // |a - b| of two signed coordinates, exact in 33 bits
   function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic [DIFF_W-1:0] d;
      d = {a[31], a} - {b[31], b};
      return d[DIFF_W-1] ? (~d + DIFF_W'(1)) : d;
   endfunction

endpackage

`default_nettype wire

[sv/pgnh_req_if.sv]
`default_nettype none

interface pgnh_req_if;
   import pgnh_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/pgnh_rsp_if.sv]
`default_nettype none

interface pgnh_rsp_if;
   import pgnh_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[sv/pgnh_ram.sv]
`default_nettype none

module pgnh_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[sv/priority_geographic_next_hop.sv]
// Geographic next-hop selector. Keeps a neighbor table (address, node type,
// position) in one synchronous RAM. A load beat appends a row (duplicate
// addresses and a full table are reported), a clear beat empties the table,
// and a query beat picks the next hop: the destination itself, else the first
// satellite that is not the previous hop, else the first such buoy if it is
// strictly nearer the destination than this node, else the nearest underwater
// neighbor; in satellite mode the nearest buoy. Nearness uses exact squared
// distances, ties to the lowest address. Every load or query scans the table
// once through a four-stage distance pipeline, one row per cycle, plus one
// slot for this node's own position; a clear skips the scan. One beat is
// worked at a time; the response register lets the next request in while
// the previous response waits. There is no clearing pass after reset.
`default_nettype none

module priority_geographic_next_hop
   import pgnh_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pgnh_req_if.sink                   req_chan,
   pgnh_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned ENTRY_W = $bits(entry_type);

   // Configuration registers
   logic               is_sat_ff;
   logic signed [31:0] self_x_ff, self_y_ff, self_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         is_sat_ff <= 1'b0;
         self_x_ff <= '0;
         self_y_ff <= '0;
         self_z_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IS_SAT: is_sat_ff <= csr_wr_data[0];
            CSR_SELF_X: self_x_ff <= csr_wr_data;
            CSR_SELF_Y: self_y_ff <= csr_wr_data;
            CSR_SELF_Z: self_z_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Control state
   state_type       state_ff, state_in;
   req_payload_type q_ff, q_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW-1:0]   issue_ff, issue_in;
   logic            rsp_vld_ff, rsp_vld_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   // Pipeline valid and self-token flags
   logic s1_vld_ff, s1_vld_in, s1_self_ff, s1_self_in;
   logic s2_vld_ff, s2_self_ff;
   logic s3_vld_ff, s3_self_ff;
   logic s4_vld_ff, s4_self_ff;

   // Scan results
   logic              hit_ff, hit_in;
   logic              sat_ok_ff, sat_ok_in;
   logic [31:0]       sat_addr_ff, sat_addr_in;
   logic              buoy_seen_ff, buoy_seen_in;
   logic              buoy_near_ff, buoy_near_in;
   logic [31:0]       buoy_addr_ff, buoy_addr_in;
   logic              best_vld_ff, best_vld_in;
   logic [DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [31:0]       best_addr_ff, best_addr_in;
   logic [DIST_W-1:0] self_dist_ff, self_dist_in;

   // Table RAM
   logic          ram_we, ram_re;
   logic [IW-1:0] ram_waddr, ram_raddr;
   entry_type     ram_wdata, ram_rdata;
   logic [CW-1:0] tok_m1;

   pgnh_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign tok_m1    = issue_ff - CW'(1);
   assign ram_raddr = tok_m1[IW-1:0];
   assign ram_waddr = count_ff[IW-1:0];
   assign ram_wdata = '{addr: q_ff.addr, node_type: q_ff.node_type,
                        pos_x: q_ff.pos_x, pos_y: q_ff.pos_y, pos_z: q_ff.pos_z};

   // Stage 1: row (or own position) minus query point
   entry_type          s1_ent;
   logic [DIFF_W-1:0]  s2_dx_ff, s2_dy_ff, s2_dz_ff;
   logic [31:0]        s2_addr_ff, s3_addr_ff, s4_addr_ff;
   logic [1:0]         s2_type_ff, s3_type_ff, s4_type_ff;
   logic [SQ_W-1:0]    s3_sqx_ff, s3_sqy_ff, s3_sqz_ff;
   logic [DIST_W-1:0]  s4_dist_ff;

   always_comb begin
      s1_ent = ram_rdata;
      if (s1_self_ff) begin
         s1_ent.pos_x = self_x_ff;
         s1_ent.pos_y = self_y_ff;
         s1_ent.pos_z = self_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      // stage 2: absolute differences
      s2_dx_ff   <= abs_diff(s1_ent.pos_x, q_ff.pos_x);
      s2_dy_ff   <= abs_diff(s1_ent.pos_y, q_ff.pos_y);
      s2_dz_ff   <= abs_diff(s1_ent.pos_z, q_ff.pos_z);
      s2_addr_ff <= s1_ent.addr;
      s2_type_ff <= s1_ent.node_type;
      // stage 3: squares
      s3_sqx_ff  <= SQ_W'(s2_dx_ff) * SQ_W'(s2_dx_ff);
      s3_sqy_ff  <= SQ_W'(s2_dy_ff) * SQ_W'(s2_dy_ff);
      s3_sqz_ff  <= SQ_W'(s2_dz_ff) * SQ_W'(s2_dz_ff);
      s3_addr_ff <= s2_addr_ff;
      s3_type_ff <= s2_type_ff;
      // stage 4: squared distance
      s4_dist_ff <= DIST_W'(s3_sqx_ff) + DIST_W'(s3_sqy_ff) + DIST_W'(s3_sqz_ff);
      s4_addr_ff <= s3_addr_ff;
      s4_type_ff <= s3_type_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s1_self_ff <= 1'b0;
         s2_self_ff <= 1'b0;
         s3_self_ff <= 1'b0;
         s4_self_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s1_vld_ff;
         s3_vld_ff  <= s2_vld_ff;
         s4_vld_ff  <= s3_vld_ff;
         s1_self_ff <= s1_self_in;
         s2_self_ff <= s1_self_ff;
         s3_self_ff <= s2_self_ff;
         s4_self_ff <= s3_self_ff;
      end
   end

   // Scan bookkeeping on the stage-4 row
   logic       row;
   logic       not_prev;
   logic [1:0] want_type;
   logic       closer;

   always_comb begin
      row       = s4_vld_ff && !s4_self_ff;
      not_prev  = s4_addr_ff != q_ff.prev_hop_addr;
      want_type = is_sat_ff ? NT_BUOY : NT_UAN;
      closer    = !best_vld_ff || (s4_dist_ff < best_dist_ff) ||
                  ((s4_dist_ff == best_dist_ff) && (s4_addr_ff < best_addr_ff));

      hit_in       = hit_ff;
      sat_ok_in    = sat_ok_ff;
      sat_addr_in  = sat_addr_ff;
      buoy_seen_in = buoy_seen_ff;
      buoy_near_in = buoy_near_ff;
      buoy_addr_in = buoy_addr_ff;
      best_vld_in  = best_vld_ff;
      best_dist_in = best_dist_ff;
      best_addr_in = best_addr_ff;
      self_dist_in = self_dist_ff;

      if (state_ff == ST_IDLE) begin
         hit_in       = 1'b0;
         sat_ok_in    = 1'b0;
         buoy_seen_in = 1'b0;
         buoy_near_in = 1'b0;
         best_vld_in  = 1'b0;
      end else begin
         if (s4_vld_ff && s4_self_ff) begin
            self_dist_in = s4_dist_ff;
         end
         if (row && (s4_addr_ff == q_ff.addr)) begin
            hit_in = 1'b1;
         end
         if (row && (s4_type_ff == NT_SAT) && not_prev && !sat_ok_ff) begin
            sat_ok_in   = 1'b1;
            sat_addr_in = s4_addr_ff;
         end
         if (row && (s4_type_ff == NT_BUOY) && not_prev && !buoy_seen_ff) begin
            buoy_seen_in = 1'b1;
            buoy_near_in = s4_dist_ff < self_dist_ff;
            buoy_addr_in = s4_addr_ff;
         end
         if (row && (s4_type_ff == want_type) && closer) begin
            best_vld_in  = 1'b1;
            best_dist_in = s4_dist_ff;
            best_addr_in = s4_addr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_ff       <= hit_in;
      sat_ok_ff    <= sat_ok_in;
      sat_addr_ff  <= sat_addr_in;
      buoy_seen_ff <= buoy_seen_in;
      buoy_near_ff <= buoy_near_in;
      buoy_addr_ff <= buoy_addr_in;
      best_vld_ff  <= best_vld_in;
      best_dist_ff <= best_dist_in;
      best_addr_ff <= best_addr_in;
      self_dist_ff <= self_dist_in;
   end

   // Controller: next state and outputs
   logic req_fire;
   logic pipe_busy;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign pipe_busy = s1_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff;

   always_comb begin
      state_in    = state_ff;
      q_in        = q_ff;
      count_in    = count_ff;
      issue_in    = issue_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_chan.ready;
      rsp_data_in = rsp_data_ff;
      s1_vld_in   = 1'b0;
      s1_self_in  = 1'b0;
      ram_re      = 1'b0;
      ram_we      = 1'b0;
      req_chan.ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_fire) begin
               q_in     = req_chan.data;
               issue_in = '0;
               case (req_chan.data.kind)
                  KIND_LOAD, KIND_QUERY: state_in = ST_SCAN;
                  KIND_CLEAR: state_in = ST_FINISH;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            // token 0 carries own position, tokens 1..n the table rows
            s1_vld_in  = 1'b1;
            s1_self_in = issue_ff == '0;
            ram_re     = issue_ff != '0;
            issue_in   = issue_ff + CW'(1);
            if (issue_ff == count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_vld_in = 1'b1;
               state_in   = ST_IDLE;
               rsp_data_in.next_hop_addr = '0;
               case (q_ff.kind)
                  KIND_LOAD: begin
                     if (hit_ff) begin
                        rsp_data_in.status = STAT_DUP;
                     end else if (count_ff == CW'(TABLE_DEPTH)) begin
                        rsp_data_in.status = STAT_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        rsp_data_in.status = STAT_LOADED;
                     end
                  end
                  KIND_QUERY: begin
                     rsp_data_in.status = STAT_FOUND;
                     if (is_sat_ff) begin
                        if (best_vld_ff) begin
                           rsp_data_in.next_hop_addr = best_addr_ff;
                        end else begin
                           rsp_data_in.status = STAT_NOROUTE;
                        end
                     end else if (hit_ff) begin
                        rsp_data_in.next_hop_addr = q_ff.addr;
                     end else if (sat_ok_ff) begin
                        rsp_data_in.next_hop_addr = sat_addr_ff;
                     end else if (buoy_seen_ff && buoy_near_ff) begin
                        rsp_data_in.next_hop_addr = buoy_addr_ff;
                     end else if (best_vld_ff) begin
                        rsp_data_in.next_hop_addr = best_addr_ff;
                     end else begin
                        rsp_data_in.status = STAT_NOROUTE;
                     end
                  end
                  default: begin
                     count_in = '0;
                     rsp_data_in.status = STAT_CLEARED;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         issue_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         issue_ff   <= issue_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff        <= q_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_DRAIN) |-> !ram_we)
      else $error("table write during scan");

   a_write_bumps_count: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> count_ff == $past(count_ff) + CW'(1))
      else $error("load write without count increment");

   a_finish_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && q_ff.kind != KIND_CLEAR) |-> !pipe_busy)
      else $error("result formed while scan still in flight");

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import pgnh_pkg::*;

   localparam int unsigned DEPTH = 16;

   // One table row as the checker sees it
   typedef struct {
      logic [31:0]        addr;
      logic [1:0]         ntype;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   pgnh_req_if req_chan ();
   pgnh_rsp_if rsp_chan ();

   priority_geographic_next_hop #(.TABLE_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state
   row_type            table_rows[DEPTH];
   int unsigned        row_count = 0;
   logic               sat_mode = 1'b0;
   logic signed [31:0] own_x = '0, own_y = '0, own_z = '0;

   req_payload_type pending_reqs[$];
   rsp_payload_type expected_rsps[$];
   int unsigned mismatches = 0;
   int unsigned rsp_seen = 0;
   int unsigned found_seen = 0;
   int unsigned noroute_seen = 0;
   bit          hold_rsp = 1'b0;
   logic        req_taken = 1'b0;

   // Append one request beat to the pending queue
   task automatic queue_req(req_payload_type r);
      pending_reqs = {pending_reqs, r};
   endtask

   function automatic logic [65:0] sq_dist(logic signed [31:0] ax, logic signed [31:0] ay,
                                           logic signed [31:0] az, logic signed [31:0] bx,
                                           logic signed [31:0] by, logic signed [31:0] bz);
      logic signed [33:0] dx, dy, dz;
      logic [65:0] sx, sy, sz;
      dx = 34'(ax) - 34'(bx);
      dy = 34'(ay) - 34'(by);
      dz = 34'(az) - 34'(bz);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dz < 0) dz = -dz;
      sx = 66'(dx[32:0]) * 66'(dx[32:0]);
      sy = 66'(dy[32:0]) * 66'(dy[32:0]);
      sz = 66'(dz[32:0]) * 66'(dz[32:0]);
      return sx + sy + sz;
   endfunction

   // Nearest row of one type; ties to lowest address
   function automatic bit nearest_hop(logic [1:0] ty, req_payload_type r,
                                      output logic [31:0] hop);
      bit have;
      logic [65:0] best, d;
      have = 1'b0;
      best = '0;
      hop = '0;
      for (int i = 0; i < row_count; i++) begin
         if (table_rows[i].ntype == ty) begin
            d = sq_dist(table_rows[i].x, table_rows[i].y, table_rows[i].z,
                        r.pos_x, r.pos_y, r.pos_z);
            if (!have || d < best || (d == best && table_rows[i].addr < hop)) begin
               have = 1'b1;
               best = d;
               hop = table_rows[i].addr;
            end
         end
      end
      return have;
   endfunction

   function automatic bit choose_hop(req_payload_type r, output logic [31:0] hop);
      hop = '0;
      if (sat_mode) return nearest_hop(NT_BUOY, r, hop);
      for (int i = 0; i < row_count; i++)
         if (table_rows[i].addr == r.addr) begin
            hop = r.addr;
            return 1'b1;
         end
      for (int i = 0; i < row_count; i++)
         if (table_rows[i].ntype == NT_SAT && table_rows[i].addr != r.prev_hop_addr) begin
            hop = table_rows[i].addr;
            return 1'b1;
         end
      // Only the first eligible buoy is considered
      for (int i = 0; i < row_count; i++)
         if (table_rows[i].ntype == NT_BUOY && table_rows[i].addr != r.prev_hop_addr) begin
            if (sq_dist(table_rows[i].x, table_rows[i].y, table_rows[i].z,
                        r.pos_x, r.pos_y, r.pos_z) <
                sq_dist(own_x, own_y, own_z, r.pos_x, r.pos_y, r.pos_z)) begin
               hop = table_rows[i].addr;
               return 1'b1;
            end
            break;
         end
      return nearest_hop(NT_UAN, r, hop);
   endfunction

   // Update the table and queue the response a beat should produce
   task automatic predict_beat(req_payload_type r);
      rsp_payload_type e;
      bit dup;
      logic [31:0] hop;
      e = '0;
      case (r.kind)
         KIND_LOAD: begin
            dup = 1'b0;
            for (int i = 0; i < row_count; i++)
               if (table_rows[i].addr == r.addr) dup = 1'b1;
            if (dup) begin
               e.status = STAT_DUP;
            end else if (row_count >= DEPTH) begin
               e.status = STAT_FULL;
            end else begin
               table_rows[row_count] = '{r.addr, r.node_type, r.pos_x, r.pos_y, r.pos_z};
               row_count++;
               e.status = STAT_LOADED;
            end
         end
         KIND_QUERY: begin
            if (choose_hop(r, hop)) begin
               e.status = STAT_FOUND;
               e.next_hop_addr = hop;
            end else begin
               e.status = STAT_NOROUTE;
            end
         end
         KIND_CLEAR: begin
            row_count = 0;
            e.status = STAT_CLEARED;
         end
         default: return;
      endcase
      expected_rsps = {expected_rsps, e};
   endtask

   // Note which edges accepted the offered request beat
   always @(posedge clock) begin
      req_taken <= req_chan.valid && req_chan.ready;
   end

   // Driver: one beat at a time from the pending queue, random gaps
   int unsigned send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.data <= '0;
      end else if (req_chan.valid && !req_taken) begin
         // hold the offered beat
      end else if (send_gap != 0) begin
         send_gap <= send_gap - 1;
         req_chan.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
         req_chan.valid <= 1'b1;
         req_chan.data <= pending_reqs.pop_front();
         send_gap <= ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // Receiver ready with random stalls, or a long hold-off
   int unsigned stall_left = 0;
   always @(negedge clock) begin
      if (reset || hold_rsp) begin
         rsp_chan.ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (rsp_chan.valid && rsp_chan.ready)
            stall_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(18);
      end
   end

   // Monitor: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      rsp_payload_type e;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) predict_beat(req_chan.data);
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_seen++;
            if (rsp_chan.data.status == STAT_FOUND) found_seen++;
            if (rsp_chan.data.status == STAT_NOROUTE) noroute_seen++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat status=%0d hop=%h",
                           rsp_chan.data.status, rsp_chan.data.next_hop_addr);
            end else begin
               e = expected_rsps.pop_front();
               if (e.status !== rsp_chan.data.status ||
                   e.next_hop_addr !== rsp_chan.data.next_hop_addr) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected status=%0d hop=%h, got status=%0d hop=%h",
                              e.status, e.next_hop_addr, rsp_chan.data.status,
                              rsp_chan.data.next_hop_addr);
               end
            end
         end
      end
   end

   // Address pool kept small so duplicates, destinations and prev hops collide
   function automatic logic [31:0] pick_addr();
      case ($urandom_range(3))
         0: return $urandom();
         1: return 32'hFFFF_FFF0 | $urandom_range(15);
         default: return $urandom_range(24);
      endcase
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7FFF_FFFF;
         default: return $urandom_range(200) - 100;
      endcase
   endfunction

   function automatic req_payload_type make_req(kind_type k);
      req_payload_type r;
      r.kind = k;
      r.addr = pick_addr();
      r.node_type = 2'($urandom_range(3));
      r.pos_x = pick_coord();
      r.pos_y = pick_coord();
      r.pos_z = pick_coord();
      r.prev_hop_addr = ($urandom_range(2) == 0) ? $urandom() : pick_addr();
      return r;
   endfunction

   function automatic req_payload_type fixed_req(logic [1:0] k, logic [31:0] a,
                                                 logic [1:0] t, logic [31:0] x,
                                                 logic [31:0] y, logic [31:0] z,
                                                 logic [31:0] p);
      req_payload_type r;
      r = '{k, a, t, x, y, z, p};
      return r;
   endfunction

   task automatic csr_write(csr_index_type idx, logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_IS_SAT: sat_mode = val[0];
         CSR_SELF_X: own_x = val;
         CSR_SELF_Y: own_y = val;
         CSR_SELF_Z: own_z = val;
         default: ;
      endcase
   endtask

   // Wait for all responses, then a scan's worth of cycles for idle
   task automatic drain();
      while (pending_reqs.size() != 0 || req_chan.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_config(logic sat, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      csr_write(CSR_IS_SAT, {31'd0, sat});
      csr_write(CSR_SELF_X, x);
      csr_write(CSR_SELF_Y, y);
      csr_write(CSR_SELF_Z, z);
   endtask

   // Stimulus
   initial begin
      req_payload_type r;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty route, all types, extremes, dup, full, ignored kind
      set_config(1'b0, 32'd0, 32'd0, 32'd0);
      queue_req(fixed_req(KIND_QUERY, 32'd5, 0, 0, 0, 0, 0));
      queue_req(fixed_req(KIND_LOAD, 32'd1, NT_UAN,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
      queue_req(fixed_req(KIND_LOAD, 32'd2, NT_UAN,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      queue_req(fixed_req(KIND_QUERY, 32'd9, 0,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
      queue_req(fixed_req(KIND_LOAD, 32'd3, NT_BUOY, 10, 0, 0, 0));
      queue_req(fixed_req(KIND_QUERY, 32'd9, 0, 0, 0, 0, 32'hFFFF_FFFF));
      queue_req(fixed_req(KIND_QUERY, 32'd9, 0, 12, 0, 0, 32'd0));
      queue_req(fixed_req(KIND_QUERY, 32'd9, 0, 12, 0, 0, 32'd3));
      queue_req(fixed_req(KIND_LOAD, 32'd4, NT_SAT, 0, 0, 0, 0));
      queue_req(fixed_req(KIND_LOAD, 32'hFFFF_FFFF, 2'd3, 1, 1, 1, 0));
      queue_req(fixed_req(KIND_QUERY, 32'd9, 0, 12, 0, 0, 32'd4));
      queue_req(fixed_req(KIND_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0));
      queue_req(fixed_req(KIND_LOAD, 32'd3, NT_SAT, 0, 0, 0, 0));
      queue_req(fixed_req(2'd3, 32'd77, NT_SAT, 0, 0, 0, 0));
      for (int i = 0; i < 13; i++)
         queue_req(fixed_req(KIND_LOAD, 32'd100 + i, 2'(i % 4), i, -i, i, 0));
      queue_req(fixed_req(KIND_LOAD, 32'd1, NT_UAN, 0, 0, 0, 0));
      queue_req(fixed_req(KIND_QUERY, 32'd9, 0, 5, 5, 5, 32'd4));
      queue_req(fixed_req(KIND_CLEAR, 0, 0, 0, 0, 0, 0));
      drain();

      // Random phases across several register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_config(1'b1, 32'd0, 32'd0, 32'd0);
            1: set_config(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
            2: set_config(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
            default: set_config(1'($urandom_range(1)), pick_coord(), pick_coord(),
                                pick_coord());
         endcase
         for (int n = 0; n < 150; n++) begin
            case ($urandom_range(19))
               0: r = make_req(KIND_CLEAR);
               1: begin r = make_req(KIND_LOAD); r.kind = 2'd3; end
               2, 3, 4, 5, 6, 7, 8: r = make_req(KIND_LOAD);
               default: r = make_req(KIND_QUERY);
            endcase
            queue_req(r);
         end
         // Long response hold-off so the block backs up its input
         if (ph == 2) begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         drain();
      end

      $display("covered %0d responses (%0d routed, %0d no route) over 9 config settings",
               rsp_seen, found_seen, noroute_seen);
      $display("table loads, duplicates, full table, clears, both routing modes exercised");
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

endmodule
